[sv/kri_pkg.sv]
`timescale 1ns / 1ps
// kri_pkg: shared types and constants of the keyframe rgb interpolator
// used by keyframe_rgb_interpolator_core and its port checker, no dependencies

package kri_pkg;

   // request kinds carried on req_tuser, the fourth code is a no-op
   typedef logic [1:0] kind_type;
   localparam kind_type KIND_KEY  = 2'd0;
   localparam kind_type KIND_TICK = 2'd1;
   localparam kind_type KIND_TAKE = 2'd2;

   // channel speed, signed fixed point
   localparam int SPEED_BITS = 34;
   typedef logic [SPEED_BITS-1:0] speed_type;

   // update threshold register
   localparam int THR_BITS = 12;
   localparam logic [THR_BITS-1:0] THR_RESET = 12'd16;

   // flag positions in rsp_tdata
   localparam int NEED_POS = 0;
   localparam int PAST_POS = 1;

endpackage

[sv/keyframe_rgb_interpolator_core.sv]
`timescale 1ns / 1ps
// keyframe_rgb_interpolator_core: linear rgb interpolation between keyframes
// bit-serial divider for speeds, shift-add multiplier for ticks; uses kri_pkg
//
//  port group | dir | payload (low bit first)
//  req_*      | in  | tuser: kind; tdata: elapsed_ms, key_time_ms, key_red/green/blue
//  rsp_*      | out | tdata: needs_update, passed_target, out_red/green/blue
//  csr_*      | in  | wr_data: update_threshold, written when wr_en is high
//
// keyframe with nonzero span: bit-serial divide, one quotient bit per cycle
// tick that interpolates: shift-add multiply, one multiplier bit per cycle
// other items go straight to the result; the next word is taken the cycle after the result is loaded
// a result waits in the output register while the next word is worked on
// reset is synchronous and clears the control and color state, threshold returns to 16; datapath regs are not reset

module keyframe_rgb_interpolator_core #(
   parameter int COLOR_BITS = 12,
   parameter int TIME_BITS  = 32,
   parameter int FRAC_BITS  = 20
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // kind
   input  logic [1:0] req_tuser,
   // elapsed_ms, key_time_ms, key_red, key_green, key_blue, zero pad
   input  logic [((2*TIME_BITS+3*COLOR_BITS+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // needs_update, passed_target, out_red, out_green, out_blue, zero pad
   output logic [((2+3*COLOR_BITS+7)/8)*8-1:0] rsp_tdata,
   input  logic csr_wr_en,
   input  logic [kri_pkg::THR_BITS-1:0] csr_wr_data
);

   localparam int C       = COLOR_BITS;
   localparam int TB      = TIME_BITS;
   localparam int F       = FRAC_BITS;
   localparam int SB      = kri_pkg::SPEED_BITS;
   localparam int OUT_BITS = 2 + 3*C;
   localparam int OUT_W   = ((OUT_BITS+7)/8)*8;
   localparam int QW      = C + F;
   localparam int PW      = SB + TB;
   localparam int WQ      = ((QW > SB) ? QW : SB) + 1;
   localparam int DW      = ((C+1) > kri_pkg::THR_BITS) ? (C+1) : kri_pkg::THR_BITS;
   localparam int CNT_MAX = (QW > TB) ? QW : TB;
   localparam int CNT_W   = $clog2(CNT_MAX);
   localparam int KT_LO   = TB;
   localparam int COL_LO  = 2*TB;

   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QW-1);
   localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(TB-1);
   localparam logic [WQ-1:0] POS_LIM = {{(WQ-SB+1){1'b0}}, {(SB-1){1'b1}}};
   localparam logic [WQ-1:0] NEG_LIM = {{(WQ-SB){1'b0}}, 1'b1, {(SB-1){1'b0}}};

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_SPD  = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;
   localparam logic [2:0] ST_EMIT = 3'd5;

   // registers
   logic [2:0]                  state_ff, state_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [kri_pkg::THR_BITS-1:0] thr_ff, thr_in;
   logic [TB-1:0]               start_time_ff, start_time_in;
   logic [TB-1:0]               goal_time_ff, goal_time_in;
   logic [C-1:0]                start_col_ff [3], start_col_in [3];
   logic [C-1:0]                goal_col_ff [3], goal_col_in [3];
   kri_pkg::speed_type          speed_ff [3], speed_in [3];
   logic [C-1:0]                exp_ff [3], exp_in [3];
   logic [C-1:0]                shown_ff [3], shown_in [3];
   logic                        past_ff, past_in;
   logic                        upd_ff, upd_in;
   logic [TB-1:0]               dvs_ff, dvs_in;
   logic [QW-1:0]               num_ff [3], num_in [3];
   logic [TB-1:0]               rem_ff [3], rem_in [3];
   logic                        qneg_ff [3], qneg_in [3];
   logic [TB-1:0]               dsr_ff, dsr_in;
   logic                        dneg_ff, dneg_in;
   logic [SB-1:0]               hi_ff [3], hi_in [3];
   logic [TB-1:0]               plo_ff [3], plo_in [3];
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]            rsp_data_ff, rsp_data_in;

   // unpacked request word
   kri_pkg::kind_type in_kind;
   logic [TB-1:0]     in_now, in_key_time;
   logic [C-1:0]      in_col [3];

   assign in_kind     = req_tuser;
   assign in_now      = req_tdata[TB-1:0];
   assign in_key_time = req_tdata[KT_LO +: TB];
   assign in_col[0]   = req_tdata[COL_LO +: C];
   assign in_col[1]   = req_tdata[COL_LO+C +: C];
   assign in_col[2]   = req_tdata[COL_LO+2*C +: C];

   // accept-time differences
   logic [TB:0]   span, delta;
   logic [TB-1:0] span_mag, delta_mag;
   logic          span_zero, passing;
   logic [C:0]    dcol [3];
   logic [C-1:0]  dcol_mag [3];

   // per-lane datapath
   logic [TB+1:0]  div_try [3];
   logic           div_ok [3];
   logic [WQ-1:0]  qx [3];
   kri_pkg::speed_type spd_new [3];
   logic [SB-1:0]  smag [3];
   logic [SB:0]    mul_sum [3];
   logic [PW-1:0]  prod [3];
   logic           lneg [3];
   logic           sticky [3];
   logic           big [3];
   logic [C:0]     mlow [3];
   logic [C:0]     csum [3];
   logic [C:0]     cdif [3];
   logic [C-1:0]   res [3];
   logic [C:0]     sdif [3];
   logic [C-1:0]   sdif_mag [3];
   logic           over [3];

   always_comb begin
      span      = {1'b0, in_key_time} - {1'b0, goal_time_ff};
      span_mag  = span[TB] ? TB'(-span) : span[TB-1:0];
      span_zero = (span == '0);
      delta     = {1'b0, in_now} - {1'b0, start_time_ff};
      delta_mag = delta[TB] ? TB'(-delta) : delta[TB-1:0];
      passing   = !past_ff && (in_now > goal_time_ff);
      for (int i = 0; i < 3; i++) begin
         dcol[i]     = {1'b0, in_col[i]} - {1'b0, goal_col_ff[i]};
         dcol_mag[i] = dcol[i][C] ? C'(-dcol[i]) : dcol[i][C-1:0];

         // restoring divide step
         div_try[i] = {1'b0, rem_ff[i], num_ff[i][QW-1]} - {2'b00, dvs_ff};
         div_ok[i]  = !div_try[i][TB+1];

         // signed speed from the quotient magnitude, saturated
         qx[i] = WQ'(num_ff[i]);
         if (!qneg_ff[i]) begin
            spd_new[i] = (qx[i] > POS_LIM) ? {1'b0, {(SB-1){1'b1}}} : qx[i][SB-1:0];
         end else begin
            spd_new[i] = (qx[i] > NEG_LIM) ? {1'b1, {(SB-1){1'b0}}} : SB'(-qx[i][SB-1:0]);
         end

         // shift-add multiply step
         smag[i]    = speed_ff[i][SB-1] ? SB'(-speed_ff[i]) : speed_ff[i];
         mul_sum[i] = {1'b0, hi_ff[i]} + (dsr_ff[0] ? {1'b0, smag[i]} : '0);

         // floor of the signed product, clamped to the color range
         prod[i]   = {hi_ff[i], plo_ff[i]};
         lneg[i]   = speed_ff[i][SB-1] ^ dneg_ff;
         sticky[i] = |prod[i][F-1:0];
         big[i]    = |prod[i][PW-1:F+C];
         mlow[i]   = {1'b0, prod[i][F+C-1:F]} + (C+1)'(lneg[i] & sticky[i]);
         csum[i]   = {1'b0, start_col_ff[i]} + {1'b0, mlow[i][C-1:0]};
         cdif[i]   = {1'b0, start_col_ff[i]} - {1'b0, mlow[i][C-1:0]};
         if (!lneg[i]) begin
            res[i] = (big[i] || mlow[i][C] || csum[i][C]) ? {C{1'b1}} : csum[i][C-1:0];
         end else begin
            res[i] = (big[i] || mlow[i][C] || cdif[i][C]) ? '0 : cdif[i][C-1:0];
         end

         sdif[i]     = {1'b0, res[i]} - {1'b0, shown_ff[i]};
         sdif_mag[i] = sdif[i][C] ? C'(-sdif[i]) : sdif[i][C-1:0];
         over[i]     = DW'(sdif_mag[i]) > DW'(thr_ff);
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      thr_in        = csr_wr_en ? csr_wr_data : thr_ff;
      start_time_in = start_time_ff;
      goal_time_in  = goal_time_ff;
      past_in       = past_ff;
      upd_in        = upd_ff;
      dvs_in        = dvs_ff;
      dsr_in        = dsr_ff;
      dneg_in       = dneg_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      for (int i = 0; i < 3; i++) begin
         start_col_in[i] = start_col_ff[i];
         goal_col_in[i]  = goal_col_ff[i];
         speed_in[i]     = speed_ff[i];
         exp_in[i]       = exp_ff[i];
         shown_in[i]     = shown_ff[i];
         num_in[i]       = num_ff[i];
         rem_in[i]       = rem_ff[i];
         qneg_in[i]      = qneg_ff[i];
         hi_in[i]        = hi_ff[i];
         plo_in[i]       = plo_ff[i];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_EMIT;
               cnt_in   = '0;
               case (in_kind)
                  kri_pkg::KIND_KEY: begin
                     start_time_in = goal_time_ff;
                     goal_time_in  = in_key_time;
                     past_in       = 1'b0;
                     dvs_in        = span_mag;
                     for (int i = 0; i < 3; i++) begin
                        start_col_in[i] = goal_col_ff[i];
                        goal_col_in[i]  = in_col[i];
                        num_in[i]       = {dcol_mag[i], {F{1'b0}}};
                        rem_in[i]       = '0;
                        qneg_in[i]      = dcol[i][C] ^ span[TB];
                        if (span_zero) begin
                           speed_in[i] = '0;
                        end
                     end
                     if (!span_zero) begin
                        state_in = ST_DIV;
                     end
                  end
                  kri_pkg::KIND_TICK: begin
                     if (passing) begin
                        past_in = 1'b1;
                        upd_in  = 1'b1;
                     end else if (!past_ff) begin
                        dsr_in  = delta_mag;
                        dneg_in = delta[TB];
                        for (int i = 0; i < 3; i++) begin
                           hi_in[i]  = '0;
                           plo_in[i] = '0;
                        end
                        state_in = ST_MUL;
                     end
                  end
                  kri_pkg::KIND_TAKE: begin
                     upd_in = 1'b0;
                     for (int i = 0; i < 3; i++) begin
                        shown_in[i] = exp_ff[i];
                     end
                  end
                  default: begin
                     state_in = ST_EMIT;
                  end
               endcase
            end
         end
         ST_DIV: begin
            for (int i = 0; i < 3; i++) begin
               rem_in[i] = div_ok[i] ? div_try[i][TB-1:0]
                                     : {rem_ff[i][TB-2:0], num_ff[i][QW-1]};
               num_in[i] = {num_ff[i][QW-2:0], div_ok[i]};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               state_in = ST_SPD;
            end
         end
         ST_SPD: begin
            for (int i = 0; i < 3; i++) begin
               speed_in[i] = spd_new[i];
            end
            state_in = ST_EMIT;
         end
         ST_MUL: begin
            for (int i = 0; i < 3; i++) begin
               hi_in[i]  = mul_sum[i][SB:1];
               plo_in[i] = {mul_sum[i][0], plo_ff[i][TB-1:1]};
            end
            dsr_in = {1'b0, dsr_ff[TB-1:1]};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == MUL_LAST) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            for (int i = 0; i < 3; i++) begin
               exp_in[i] = res[i];
            end
            upd_in   = over[0] || over[1] || over[2];
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // load the result word once the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = OUT_W'({exp_ff[2], exp_ff[1], exp_ff[0], past_ff, upd_ff});
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         thr_ff        <= kri_pkg::THR_RESET;
         start_time_ff <= '0;
         goal_time_ff  <= '0;
         past_ff       <= 1'b0;
         upd_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            start_col_ff[i] <= '0;
            goal_col_ff[i]  <= '0;
            speed_ff[i]     <= '0;
            exp_ff[i]       <= '0;
            shown_ff[i]     <= '0;
         end
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         thr_ff        <= thr_in;
         start_time_ff <= start_time_in;
         goal_time_ff  <= goal_time_in;
         past_ff       <= past_in;
         upd_ff        <= upd_in;
         rsp_valid_ff  <= rsp_valid_in;
         for (int i = 0; i < 3; i++) begin
            start_col_ff[i] <= start_col_in[i];
            goal_col_ff[i]  <= goal_col_in[i];
            speed_ff[i]     <= speed_in[i];
            exp_ff[i]       <= exp_in[i];
            shown_ff[i]     <= shown_in[i];
         end
      end
   end

   // datapath shift registers, no reset
   always_ff @(posedge clock) begin
      dvs_ff      <= dvs_in;
      dsr_ff      <= dsr_in;
      dneg_ff     <= dneg_in;
      rsp_data_ff <= rsp_data_in;
      for (int i = 0; i < 3; i++) begin
         num_ff[i]  <= num_in[i];
         rem_ff[i]  <= rem_in[i];
         qneg_ff[i] <= qneg_in[i];
         hi_ff[i]   <= hi_in[i];
         plo_ff[i]  <= plo_in[i];
      end
   end

endmodule

[sv/kri_chk.sv]
`timescale 1ns / 1ps
// kri_chk: port-level checker for keyframe_rgb_interpolator_core
// uses kri_pkg, attached to the top level by the bind at the end of this file

module kri_chk #(
   parameter int COLOR_BITS = 12
) (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic [1:0] req_tuser,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [((2+3*COLOR_BITS+7)/8)*8-1:0] rsp_tdata
);

   // kind of the last accepted word
   logic              seen_ff, seen_in;
   kri_pkg::kind_type kind_ff, kind_in;
   logic              req_acc;

   assign req_acc = req_tvalid && req_tready;

   always_comb begin
      seen_in = seen_ff || req_acc;
      kind_in = req_acc ? req_tuser : kind_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
         kind_ff <= kri_pkg::KIND_TICK;
      end else begin
         seen_ff <= seen_in;
         kind_ff <= kind_in;
      end
   end

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_tready)
      else $error("request taken while a word is in work");

   a_result_on_ready: assert property (@(posedge clock) disable iff (reset)
      ($rose(req_tready) && seen_ff) |-> rsp_tvalid)
      else $error("ready returned without a result word");

   a_key_clears_past: assert property (@(posedge clock) disable iff (reset)
      ($rose(req_tready) && seen_ff && kind_ff == kri_pkg::KIND_KEY)
         |-> !rsp_tdata[kri_pkg::PAST_POS])
      else $error("passed_target set after a keyframe");

   a_take_clears_need: assert property (@(posedge clock) disable iff (reset)
      ($rose(req_tready) && seen_ff && kind_ff == kri_pkg::KIND_TAKE)
         |-> !rsp_tdata[kri_pkg::NEED_POS])
      else $error("needs_update set after a take");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result word changed");

endmodule

bind keyframe_rgb_interpolator_core kri_chk #(
   .COLOR_BITS(COLOR_BITS)
) u_kri_chk (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .req_tuser (req_tuser),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);
